FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked assertion, disabled during reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

FILE: hdl/iptr_pkg.sv
// Types, constants and helper functions of the IPv4 prefix trie.
// Depends on nothing.
package iptr_pkg;
  localparam int POOL_NODES = 1024;
  localparam int NODE_AW = $clog2(POOL_NODES);
  localparam int PTR_W = NODE_AW + 1;
  localparam int KEY_BITS = 32;
  localparam int PLEN_W = 6;
  localparam logic [PTR_W-1:0] NIL_PTR = {1'b1, {NODE_AW{1'b0}}};
  localparam logic [PTR_W-1:0] ROOM_LIMIT = PTR_W'(POOL_NODES - 2);
  localparam logic [PLEN_W-1:0] FULL_PLEN = 6'd32;

  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;
  localparam logic [1:0] REQ_SPARE  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_LEN  = 2'd1;
  localparam logic [1:0] ST_POOL_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]          req_type;
    logic [KEY_BITS-1:0] address;
    logic [PLEN_W-1:0]   prefix_len;
  } req_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] status;
  } rsp_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [PLEN_W-1:0]   plen;
    logic                mark;
    logic [PTR_W-1:0]    child0;
    logic [PTR_W-1:0]    child1;
  } node_t;

  localparam int NODE_W = $bits(node_t);

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_EV, S_W_FRESH, S_W_SPLIT, S_W_PARENT, S_DONE
  } state_t;

  function automatic logic branch_bit(input logic [KEY_BITS-1:0] key,
                                      input logic [PLEN_W-1:0] plen);
    if (plen >= FULL_PLEN) return 1'b0;
    return key[5'(6'd31 - plen)];
  endfunction

  function automatic logic covers(input logic [KEY_BITS-1:0] nkey,
                                  input logic [PLEN_W-1:0] plen,
                                  input logic [KEY_BITS-1:0] key);
    logic [KEY_BITS-1:0] mask;
    mask = {KEY_BITS{1'b1}} << (FULL_PLEN - plen);
    return ((nkey ^ key) & mask) == '0;
  endfunction

  function automatic logic [PLEN_W-1:0] lead_zeros(input logic [KEY_BITS-1:0] x);
    logic [PLEN_W-1:0] n;
    n = FULL_PLEN;
    for (int i = 0; i < KEY_BITS; i++) begin
      if (x[i]) n = PLEN_W'(KEY_BITS - 1 - i);
    end
    return n;
  endfunction
endpackage

FILE: hdl/iptr_node_ram.sv
// Single-port-write, single-port-read node memory with registered read data.
// Depends on nothing.
module iptr_node_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 61,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: hdl/ipv4_prefix_set_trie.sv
// Node compare of the IPv4 prefix trie walk: coverage, length test, child select.
// Depends on iptr_pkg.
module iptr_walk_cmp import iptr_pkg::*; (
  input  node_t               rec,
  input  logic [KEY_BITS-1:0] key,
  input  logic [PLEN_W-1:0]   plen,
  output logic                cov,
  output logic                le,
  output logic [PTR_W-1:0]    child
);
  assign cov = covers(rec.key, rec.plen, key);
  assign le = rec.plen <= plen;
  assign child = branch_bit(key, rec.plen) ? rec.child1 : rec.child0;
endmodule

FILE: hdl/ipv4_prefix_set_trie_core.sv
// Lookup and insert visit up to 33 trie levels, each by a memory read (S_RD) and a
// compare (S_EV); an insert then writes in S_W_FRESH, S_W_SPLIT, S_W_PARENT as needed.
// Clear, unused codes and rejected lengths go to S_DONE. One word is in work at a time.
// Reset (synchronous, active high) empties the set; node memory is not cleared.
// Depends on iptr_pkg, iptr_node_ram and iptr_walk_cmp.
module ipv4_prefix_set_trie_core import iptr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);
  state_t state, state_next;
  req_t cur_req;
  logic [PTR_W-1:0] root, next_free, cur, parent, down, hang, fresh;
  node_t prec, rec, wrec;
  logic [KEY_BITS-1:0] dkey;
  logic down_valid, found;
  logic [1:0] status;
  logic [PLEN_W-1:0] split;
  logic we;
  logic [NODE_AW-1:0] waddr;
  logic cov, le;
  logic [PTR_W-1:0] child;
  logic room, is_lookup, pass, is_split;
  logic [PLEN_W-1:0] lz;

  iptr_node_ram #(.DEPTH(POOL_NODES), .WIDTH(NODE_W)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wrec),
    .raddr(cur[NODE_AW-1:0]), .rdata(rec)
  );

  iptr_walk_cmp u_cmp (
    .rec(rec), .key(cur_req.address), .plen(cur_req.prefix_len),
    .cov(cov), .le(le), .child(child)
  );

  assign room = next_free <= ROOM_LIMIT;
  assign is_lookup = cur_req.req_type == REQ_LOOKUP;
  assign pass = cov && (is_lookup || le);
  assign lz = lead_zeros(dkey ^ cur_req.address);
  assign split = (lz > cur_req.prefix_len) ? cur_req.prefix_len : lz;
  assign is_split = down_valid && (split != cur_req.prefix_len);
  assign req_ready = state == S_IDLE;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (req_valid) begin
        unique case (req.req_type)
          REQ_LOOKUP: state_next = S_RD;
          REQ_INSERT: state_next = (req.prefix_len > FULL_PLEN) ? S_DONE : S_RD;
          default:    state_next = S_DONE;
        endcase
      end
      S_RD: begin
        if (!cur[NODE_AW]) state_next = S_EV;
        else if (is_lookup || !room) state_next = S_DONE;
        else state_next = S_W_FRESH;
      end
      S_EV: begin
        if (is_lookup) begin
          state_next = (cov && rec.plen < FULL_PLEN) ? S_RD : S_DONE;
        end else if (pass) begin
          state_next = (rec.plen == cur_req.prefix_len) ? S_DONE : S_RD;
        end else begin
          state_next = room ? S_W_FRESH : S_DONE;
        end
      end
      S_W_FRESH:  state_next = is_split ? S_W_SPLIT : S_W_PARENT;
      S_W_SPLIT:  state_next = S_W_PARENT;
      S_W_PARENT: state_next = S_DONE;
      S_DONE:     if (!rsp_valid || rsp_ready) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    we = 1'b0;
    waddr = cur[NODE_AW-1:0];
    wrec = rec;
    unique case (state)
      S_EV: begin
        if (!is_lookup && pass && rec.plen == cur_req.prefix_len) begin
          we = 1'b1;
          wrec.mark = 1'b1;
        end
      end
      S_W_FRESH: begin
        we = 1'b1;
        waddr = next_free[NODE_AW-1:0];
        wrec.key = cur_req.address;
        wrec.plen = cur_req.prefix_len;
        wrec.mark = 1'b1;
        wrec.child0 = NIL_PTR;
        wrec.child1 = NIL_PTR;
        if (down_valid && !is_split) begin
          if (branch_bit(dkey, cur_req.prefix_len)) wrec.child1 = down;
          else wrec.child0 = down;
        end
      end
      S_W_SPLIT: begin
        we = 1'b1;
        waddr = next_free[NODE_AW-1:0];
        wrec.key = cur_req.address;
        wrec.plen = split;
        wrec.mark = 1'b0;
        if (branch_bit(dkey, split)) begin
          wrec.child1 = down;
          wrec.child0 = fresh;
        end else begin
          wrec.child0 = down;
          wrec.child1 = fresh;
        end
      end
      S_W_PARENT: begin
        we = !parent[NODE_AW];
        waddr = parent[NODE_AW-1:0];
        wrec = prec;
        if (branch_bit(cur_req.address, prec.plen)) wrec.child1 = hang;
        else wrec.child0 = hang;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      root <= NIL_PTR;
      next_free <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp_valid && rsp_ready && state != S_DONE) rsp_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (req_valid) begin
          cur_req <= req;
          cur <= root;
          parent <= NIL_PTR;
          found <= 1'b0;
          status <= (req.req_type == REQ_INSERT && req.prefix_len > FULL_PLEN) ?
                    ST_BAD_LEN : ST_OK;
          if (req.req_type == REQ_CLEAR) begin
            root <= NIL_PTR;
            next_free <= '0;
          end
        end
        S_RD: begin
          down_valid <= 1'b0;
          down <= cur;
          if (cur[NODE_AW] && !is_lookup && !room) status <= ST_POOL_FULL;
        end
        S_EV: begin
          if (is_lookup) begin
            if (cov && rec.mark) found <= 1'b1;
            cur <= child;
          end else if (pass) begin
            parent <= cur;
            prec <= rec;
            cur <= child;
          end else begin
            down_valid <= 1'b1;
            down <= cur;
            dkey <= rec.key;
            if (!room) status <= ST_POOL_FULL;
          end
        end
        S_W_FRESH: begin
          fresh <= next_free;
          hang <= next_free;
          next_free <= next_free + 1'b1;
        end
        S_W_SPLIT: begin
          hang <= next_free;
          next_free <= next_free + 1'b1;
        end
        S_W_PARENT: if (parent[NODE_AW]) root <= hang;
        S_DONE: if (!rsp_valid || rsp_ready) begin
          rsp_valid <= 1'b1;
          rsp.hit <= is_lookup & found;
          rsp.status <= (cur_req.req_type == REQ_INSERT) ? status : ST_OK;
        end
        default: ;
      endcase
    end
  end
endmodule

FILE: hdl/iptr_checker.sv
// Port-level checks of the prefix trie core, bound to the top level.
// Depends on iptr_pkg and assert_macros.svh.
`include "assert_macros.svh"
module iptr_checker import iptr_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);
  `ASSERT_CLK(a_busy_after_accept, clk, rst, req_valid && req_ready |=> !req_ready, "accept twice")
  `ASSERT_CLK(a_status_code, clk, rst, rsp_valid |-> rsp.status <= ST_POOL_FULL, "bad status code")
  `ASSERT_CLK(a_hit_status, clk, rst, rsp_valid && rsp.hit |-> rsp.status == ST_OK, "hit status")
  `ASSERT_CLK(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp), "hold")
endmodule

bind ipv4_prefix_set_trie_core iptr_checker u_iptr_checker (.*);
